// ===== rtl/stx_etx_frame_receiver_assert.svh =====
// Assertion macros for the STX/ETX frame receiver.
// Used by the frame controller (sefr_rx_ctrl), which checks its own control logic; empty in synthesis.
`ifndef STX_ETX_FRAME_RECEIVER_ASSERT_SVH
`define STX_ETX_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked on the given clock, ignored while the given reset is low.
`define SEFR_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on the house clock and reset.
`define SEFR_ASSERT(label, prop, msg) \
  `SEFR_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`else

`define SEFR_ASSERT_CLK(label, clk, rstn, prop, msg)
`define SEFR_ASSERT(label, prop, msg)

`endif

`endif

// ===== rtl/sefr_pkg.sv =====
// Types and constants of the STX/ETX frame receiver.
// Used by the interfaces and all RTL modules; depends on nothing.
package sefr_pkg;

  // Field widths fixed by the item formats.
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned TMO_W      = 16;
  localparam int unsigned TICK_W     = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register values after reset.
  localparam logic [DATA_W-1:0] START_RST   = 8'd2;
  localparam logic [DATA_W-1:0] END_RST     = 8'd3;
  localparam logic [LEN_W-1:0]  SIZE_RST    = 7'd64;
  localparam logic [TMO_W-1:0]  TIMEOUT_RST = 16'd100;

  // Kind of an input item.
  typedef enum logic [MODE_W-1:0] {
    MODE_BYTE = 2'd0,
    MODE_TICK = 2'd1,
    MODE_EVAL = 2'd2
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START   = 2'd0,
    CFG_END     = 2'd1,
    CFG_SIZE    = 2'd2,
    CFG_TIMEOUT = 2'd3
  } cfg_reg_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_STREAM = 1'b1
  } state_e;

  // Configuration as seen by the controller.
  typedef struct packed {
    logic [DATA_W-1:0] start_byte;
    logic [DATA_W-1:0] end_byte;
    logic [LEN_W-1:0]  rx_size;
    logic [TMO_W-1:0]  rx_timeout;
  } cfg_t;

  // One cycle of requests to the frame memory.
  typedef struct packed {
    logic              we;
    logic [POS_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [POS_W-1:0]  raddr;
  } mem_req_t;

  // Description of a byte whose read has been issued.
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len;
    logic             last;
  } rd_meta_t;

endpackage

// ===== rtl/sefr_if.sv =====
// Handshake channels of the STX/ETX frame receiver: input items and result items.
// Depends on sefr_pkg for the field widths.
interface sefr_in_if;
  logic                           valid;
  logic                           ready;
  logic [sefr_pkg::MODE_W-1:0]    mode;
  logic [sefr_pkg::DATA_W-1:0]    data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface sefr_out_if;
  logic                           valid;
  logic                           ready;
  logic [sefr_pkg::DATA_W-1:0]    frame_byte;
  logic [sefr_pkg::POS_W-1:0]     byte_position;
  logic [sefr_pkg::LEN_W-1:0]     frame_length;
  logic                           last;

  modport source (output valid, output frame_byte, output byte_position,
                  output frame_length, output last, input ready);
  modport sink (input valid, input frame_byte, input byte_position,
                input frame_length, input last, output ready);
endinterface

// ===== rtl/sefr_frame_mem.sv =====
// Frame byte store: one write port and one read port with registered read data.
// Depends on sefr_pkg for the request type.
module sefr_frame_mem #(
  parameter int unsigned RX_DEPTH = 64
) (
  input  logic                        clk_i,
  input  sefr_pkg::mem_req_t          req_i,
  output logic [sefr_pkg::DATA_W-1:0] rdata_o
);

  localparam int unsigned AW = $clog2(RX_DEPTH);

  logic [sefr_pkg::DATA_W-1:0] mem_q [RX_DEPTH];
  logic [sefr_pkg::DATA_W-1:0] rdata_q;

  // Write and read; read data changes only when a read is issued.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sefr_out_stage.sv =====
// Read-return and output registers: pair memory read data with its position
// and hold the result item until taken. Depends on sefr_pkg and sefr_out_if.
module sefr_out_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        issue_i,
  input  sefr_pkg::rd_meta_t          meta_i,
  input  logic [sefr_pkg::DATA_W-1:0] rdata_i,
  output logic                        slot_free_o,
  sefr_out_if.source                  out_o
);

  logic               rd_vld_q, rd_vld_d;
  sefr_pkg::rd_meta_t meta_q;
  logic               out_vld_q, out_vld_d;
  logic [sefr_pkg::DATA_W-1:0] byte_q;
  sefr_pkg::rd_meta_t          out_meta_q;
  logic               can_load;

  // The output register can take new data when empty or being taken.
  assign can_load    = !out_vld_q || out_o.ready;
  assign slot_free_o = !rd_vld_q || can_load;

  always_comb begin
    rd_vld_d = rd_vld_q;
    if (issue_i) begin
      rd_vld_d = 1'b1;
    end else if (can_load) begin
      rd_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (can_load) begin
      out_vld_d = rd_vld_q;
    end
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      meta_q <= meta_i;
    end
    if (can_load && rd_vld_q) begin
      byte_q     <= rdata_i;
      out_meta_q <= meta_q;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.frame_byte    = byte_q;
  assign out_o.byte_position = out_meta_q.pos;
  assign out_o.frame_length  = out_meta_q.len;
  assign out_o.last          = out_meta_q.last;

endmodule

// ===== rtl/sefr_rx_ctrl.sv =====
// Frame controller: accepts items, builds the frame in the store, counts ticks
// and streams a ready frame out. Depends on sefr_pkg, sefr_in_if and the macros.
`include "stx_etx_frame_receiver_assert.svh"

module sefr_rx_ctrl #(
  parameter int unsigned RX_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sefr_pkg::cfg_t       cfg_i,
  input  logic                 slot_free_i,
  sefr_in_if.sink              in_i,
  output sefr_pkg::mem_req_t   mem_req_o,
  output logic                 issue_o,
  output sefr_pkg::rd_meta_t   meta_o
);

  localparam logic [sefr_pkg::LEN_W-1:0] DEPTH_L = sefr_pkg::LEN_W'(RX_DEPTH);

  sefr_pkg::state_e state_q, state_d;
  logic [sefr_pkg::LEN_W-1:0]  fill_q, fill_d;
  logic                        ready_q, ready_d;
  logic [sefr_pkg::TICK_W-1:0] tick_q, tick_d;
  logic [sefr_pkg::LEN_W-1:0]  len_q, len_d;
  logic [sefr_pkg::LEN_W-1:0]  rd_idx_q, rd_idx_d;

  logic                        in_acc;
  logic                        in_rdy;
  logic                        rd_last;
  logic [sefr_pkg::LEN_W-1:0]  limit;
  logic [sefr_pkg::LEN_W-1:0]  fill_inc;

  assign in_acc   = in_i.valid && in_rdy;
  assign rd_last  = (rd_idx_q + 7'd1) == len_q;
  assign limit    = (cfg_i.rx_size > DEPTH_L) ? DEPTH_L : cfg_i.rx_size;
  assign fill_inc = fill_q + 7'd1;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sefr_pkg::ST_IDLE: begin
        if (in_acc && in_i.mode == sefr_pkg::MODE_EVAL && ready_q) begin
          state_d = sefr_pkg::ST_STREAM;
        end
      end
      sefr_pkg::ST_STREAM: begin
        if (issue_o && rd_last) begin
          state_d = sefr_pkg::ST_IDLE;
        end
      end
      default: state_d = sefr_pkg::ST_IDLE;
    endcase
  end

  // State outputs: take items when idle, read one byte per free slot when streaming.
  always_comb begin
    in_rdy  = 1'b0;
    issue_o = 1'b0;
    unique case (state_q)
      sefr_pkg::ST_IDLE:   in_rdy  = 1'b1;
      sefr_pkg::ST_STREAM: issue_o = slot_free_i;
      default: begin
        in_rdy  = 1'b0;
        issue_o = 1'b0;
      end
    endcase
  end

  assign in_i.ready = in_rdy;

  // Frame bookkeeping and store writes.
  always_comb begin
    fill_d    = fill_q;
    ready_d   = ready_q;
    tick_d    = tick_q;
    len_d     = len_q;
    rd_idx_d  = rd_idx_q;
    mem_req_o = '0;
    mem_req_o.wdata = in_i.data_byte;
    mem_req_o.raddr = rd_idx_q[sefr_pkg::POS_W-1:0];
    mem_req_o.re    = issue_o;

    if (in_acc) begin
      if (in_i.mode == sefr_pkg::MODE_BYTE) begin
        if (!ready_q) begin
          if (fill_q == '0) begin
            // Idle: only the start byte opens a frame.
            if (in_i.data_byte == cfg_i.start_byte) begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = '0;
              fill_d          = 7'd1;
            end
          end else if (in_i.data_byte == cfg_i.end_byte) begin
            ready_d = 1'b1;
          end else begin
            // Store the byte; drop the frame when the size limit is reached.
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = fill_q[sefr_pkg::POS_W-1:0];
            if (fill_inc >= limit) begin
              fill_d = '0;
              tick_d = '0;
            end else begin
              fill_d = fill_inc;
            end
          end
        end
      end else if (in_i.mode == sefr_pkg::MODE_TICK) begin
        if (fill_q != '0 && !ready_q) begin
          if (tick_q > {1'b0, cfg_i.rx_timeout}) begin
            fill_d = '0;
            tick_d = '0;
          end else begin
            tick_d = tick_q + 17'd1;
          end
        end
      end else if (in_i.mode == sefr_pkg::MODE_EVAL) begin
        // Start streaming and clear the frame; the length is kept for the results.
        if (ready_q) begin
          len_d    = fill_q;
          rd_idx_d = '0;
          ready_d  = 1'b0;
          fill_d   = '0;
          tick_d   = '0;
        end
      end
    end

    if (issue_o) begin
      rd_idx_d = rd_idx_q + 7'd1;
    end
  end

  assign meta_o.pos  = rd_idx_q[sefr_pkg::POS_W-1:0];
  assign meta_o.len  = len_q;
  assign meta_o.last = rd_last;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sefr_pkg::ST_IDLE;
      fill_q   <= '0;
      ready_q  <= 1'b0;
      tick_q   <= '0;
      len_q    <= '0;
      rd_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      ready_q  <= ready_d;
      tick_q   <= tick_d;
      len_q    <= len_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  // A ready frame always holds at least the start byte, within the store.
  `SEFR_ASSERT(a_ready_nonempty, ready_q |-> (fill_q != '0 && fill_q < DEPTH_L), "ready frame is empty or too long")
  // Streaming never reads past the frame length.
  `SEFR_ASSERT(a_stream_in_range, (state_q == sefr_pkg::ST_STREAM) |-> (rd_idx_q < len_q && len_q != '0), "stream index out of range")
  // An evaluate on a ready frame starts the stream with the frame cleared.
  `SEFR_ASSERT(a_eval_starts, (in_acc && in_i.mode == sefr_pkg::MODE_EVAL && ready_q) |=> (state_q == sefr_pkg::ST_STREAM && !ready_q && fill_q == '0), "evaluate did not start stream")

endmodule

// ===== rtl/stx_etx_frame_receiver.sv =====
// STX/ETX frame receiver. Bytes and ticks are taken while the controller is idle; an evaluate on a
// ready frame of n bytes streams them out through the store's read register and the output register,
// one byte per cycle while the sink takes them, one memory read per byte.
// The next item is accepted once the last byte's read has been issued.
// Reset clears the configuration, valid flags and control state; the frame store and payload registers are not cleared.
module stx_etx_frame_receiver #(
  parameter int unsigned RX_DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sefr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sefr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  sefr_in_if.sink                         in_i,
  sefr_out_if.source                      out_o
);

  sefr_pkg::cfg_t     cfg_q;
  sefr_pkg::mem_req_t mem_req;
  sefr_pkg::rd_meta_t meta;
  logic               issue;
  logic               slot_free;
  logic [sefr_pkg::DATA_W-1:0] rdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte <= sefr_pkg::START_RST;
      cfg_q.end_byte   <= sefr_pkg::END_RST;
      cfg_q.rx_size    <= sefr_pkg::SIZE_RST;
      cfg_q.rx_timeout <= sefr_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (sefr_pkg::cfg_reg_e'(cfg_idx_i))
        sefr_pkg::CFG_START:   cfg_q.start_byte <= cfg_wdata_i[sefr_pkg::DATA_W-1:0];
        sefr_pkg::CFG_END:     cfg_q.end_byte   <= cfg_wdata_i[sefr_pkg::DATA_W-1:0];
        sefr_pkg::CFG_SIZE:    cfg_q.rx_size    <= cfg_wdata_i[sefr_pkg::LEN_W-1:0];
        sefr_pkg::CFG_TIMEOUT: cfg_q.rx_timeout <= cfg_wdata_i[sefr_pkg::TMO_W-1:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  sefr_rx_ctrl #(
    .RX_DEPTH (RX_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .slot_free_i (slot_free),
    .in_i        (in_i),
    .mem_req_o   (mem_req),
    .issue_o     (issue),
    .meta_o      (meta)
  );

  sefr_frame_mem #(
    .RX_DEPTH (RX_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  sefr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .meta_i      (meta),
    .rdata_i     (rdata),
    .slot_free_o (slot_free),
    .out_o       (out_o)
  );

endmodule

// ===== dv/stx_etx_frame_receiver_tb.sv =====
// Self-checking testbench for the STX/ETX frame receiver.
// Drives bytes, ticks and evaluate requests with random gaps and stalls, predicts every
// emitted frame byte and scores it. Depends on sefr_pkg, sefr_if.sv and the RTL top.
module stx_etx_frame_receiver_tb;

  localparam int unsigned FRAME_DEPTH   = 64;
  localparam int unsigned PHASE_ITEMS   = 12;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam int unsigned MAX_SHOWN     = 10;

  typedef logic [sefr_pkg::MODE_W-1:0]     mode_t;
  typedef logic [sefr_pkg::DATA_W-1:0]     byte_t;
  typedef logic [sefr_pkg::LEN_W-1:0]      len_t;
  typedef logic [sefr_pkg::TMO_W-1:0]      tmo_t;
  typedef logic [sefr_pkg::CFG_DATA_W-1:0] cfg_data_t;

  // Mode value that the block has no use for.
  localparam mode_t MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [sefr_pkg::MODE_W-1:0] mode;
    logic [sefr_pkg::DATA_W-1:0] data;
  } rx_item_t;

  typedef struct packed {
    logic [sefr_pkg::DATA_W-1:0] frame_byte;
    logic [sefr_pkg::POS_W-1:0]  pos;
    logic [sefr_pkg::LEN_W-1:0]  len;
    logic                        last;
  } frame_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [sefr_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [sefr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  sefr_in_if  in_ch ();
  sefr_out_if out_ch ();

  stx_etx_frame_receiver #(
    .RX_DEPTH(FRAME_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // Predictor copy of the registers and the receive buffer.
  byte_t       sof_val = sefr_pkg::START_RST;
  byte_t       eof_val = sefr_pkg::END_RST;
  len_t        size_val = sefr_pkg::SIZE_RST;
  tmo_t        tmo_val = sefr_pkg::TIMEOUT_RST;
  byte_t       buf_mem [FRAME_DEPTH];
  int unsigned buf_fill = 0;
  bit          buf_done = 1'b0;
  int unsigned buf_ticks = 0;

  rx_item_t   pending_items [$];
  frame_out_t frame_expect [$];

  // Handshake bookkeeping shared by the driver, the receiver and the stimulus.
  bit          in_fire = 1'b0;
  bit          out_fire = 1'b0;
  bit          tx_busy = 1'b0;
  rx_item_t    tx_cur = '0;
  int unsigned tx_gap = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int unsigned rx_gap = 0;
  int unsigned hold_gen = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  int unsigned items_planned = 0;
  int unsigned items_taken = 0;
  int unsigned results_checked = 0;
  int unsigned frames_seen = 0;
  int unsigned settings_used = 0;
  int unsigned mismatches = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_wait(bit on);
    return on ? $urandom_range(0, 14) : 0;
  endfunction

  function automatic void report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("[%0t] %s", $time, what);
    end
  endfunction

  // Advances the predicted receiver by one item and queues the bytes it emits.
  function automatic void frame_model_step(mode_t mode, byte_t b);
    int unsigned lim;
    frame_out_t  r;
    lim = 32'(size_val);
    if (lim > FRAME_DEPTH) begin
      lim = FRAME_DEPTH;
    end
    case (mode)
      sefr_pkg::MODE_BYTE: begin
        if (!buf_done) begin
          if (buf_fill == 0) begin
            if (b == sof_val) begin
              buf_mem[0] = b;
              buf_fill = 1;
            end
          end else if (b == eof_val) begin
            buf_done = 1'b1;
          end else begin
            buf_mem[buf_fill[sefr_pkg::POS_W-1:0]] = b;
            buf_fill++;
            // Store full before the end byte: the partial frame is discarded.
            if (buf_fill >= lim || buf_fill >= FRAME_DEPTH) begin
              buf_fill = 0;
              buf_ticks = 0;
            end
          end
        end
      end
      sefr_pkg::MODE_TICK: begin
        if (buf_fill != 0 && !buf_done) begin
          if (buf_ticks > 32'(tmo_val)) begin
            buf_fill = 0;
            buf_ticks = 0;
          end else begin
            buf_ticks++;
          end
        end
      end
      sefr_pkg::MODE_EVAL: begin
        if (buf_done) begin
          for (int unsigned k = 0; k < buf_fill; k++) begin
            r.frame_byte = buf_mem[k[sefr_pkg::POS_W-1:0]];
            r.pos        = k[sefr_pkg::POS_W-1:0];
            r.len        = buf_fill[sefr_pkg::LEN_W-1:0];
            r.last       = (k + 1 == buf_fill);
            frame_expect.push_back(r);
          end
          buf_done  = 1'b0;
          buf_fill  = 0;
          buf_ticks = 0;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Input driver: takes items from the pending queue, with a random gap before each.
  always @(negedge clk_i) begin : drive_in
    logic next_valid;
    next_valid = 1'b0;
    if (in_fire) begin
      tx_busy = 1'b0;
    end
    if (!tx_busy && pending_items.size() > 0) begin
      tx_cur  = pending_items.pop_front();
      tx_gap  = draw_wait(tx_idle_on);
      tx_busy = 1'b1;
    end
    if (tx_busy) begin
      if (tx_gap > 0) begin
        tx_gap--;
      end else begin
        next_valid = 1'b1;
      end
    end
    in_ch.valid     <= next_valid;
    in_ch.mode      <= tx_cur.mode;
    in_ch.data_byte <= tx_cur.data;
  end

  // Result receiver: random stall before each item, plus an occasional long hold-off.
  always @(negedge clk_i) begin : drive_out
    logic next_ready;
    if (out_fire) begin
      rx_gap = draw_wait(rx_idle_on);
    end
    if (hold_seen != hold_gen) begin
      hold_seen = hold_gen;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      next_ready = 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      next_ready = 1'b0;
    end else begin
      next_ready = 1'b1;
    end
    out_ch.ready <= next_ready;
  end

  // Monitor: feeds accepted inputs to the predictor and scores accepted results.
  always @(posedge clk_i) begin : monitor
    frame_out_t want;
    in_fire  = rst_ni && in_ch.valid && in_ch.ready;
    out_fire = rst_ni && out_ch.valid && out_ch.ready;
    if (in_fire) begin
      frame_model_step(in_ch.mode, in_ch.data_byte);
      items_taken++;
    end
    if (out_fire) begin
      if (frame_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected result: byte %02h pos %0d len %0d last %0b",
                                  out_ch.frame_byte, out_ch.byte_position,
                                  out_ch.frame_length, out_ch.last));
      end else begin
        want = frame_expect.pop_front();
        results_checked++;
        if (out_ch.frame_byte !== want.frame_byte || out_ch.byte_position !== want.pos ||
            out_ch.frame_length !== want.len || out_ch.last !== want.last) begin
          report_mismatch($sformatf(
              "expected byte %02h pos %0d len %0d last %0b, got byte %02h pos %0d len %0d last %0b",
              want.frame_byte, want.pos, want.len, want.last, out_ch.frame_byte,
              out_ch.byte_position, out_ch.frame_length, out_ch.last));
        end
        if (want.last) begin
          frames_seen++;
        end
      end
    end
  end

  // Hard stop if the run hangs.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void push_item(mode_t mode, byte_t data);
    rx_item_t it;
    it.mode = mode;
    it.data = data;
    pending_items.push_back(it);
    items_planned++;
  endfunction

  // A random body byte that cannot close the frame.
  function automatic byte_t body_byte();
    byte_t v;
    v = byte_t'($urandom);
    if (v == eof_val) begin
      v = v ^ 8'h01;
    end
    return v;
  endfunction

  // Well-formed frame with a few ticks mixed in, kept inside the tick budget.
  function automatic void push_frame(int unsigned body_len);
    int unsigned ticks;
    ticks = 0;
    push_item(sefr_pkg::MODE_BYTE, sof_val);
    repeat (body_len) begin
      if ($urandom_range(0, 3) == 0 && ticks <= 32'(tmo_val)) begin
        push_item(sefr_pkg::MODE_TICK, byte_t'($urandom));
        ticks++;
      end
      push_item(sefr_pkg::MODE_BYTE, body_byte());
    end
    push_item(sefr_pkg::MODE_BYTE, eof_val);
  endfunction

  // Waits until every item is sent and every predicted byte has come back.
  task automatic drain();
    while (pending_items.size() != 0 || tx_busy || frame_expect.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all four registers, with junk in the unused upper data bits.
  task automatic load_settings(byte_t s, byte_t e, len_t z, tmo_t t);
    cfg_data_t junk;
    junk = cfg_data_t'($urandom);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= sefr_pkg::CFG_START;
    cfg_wdata <= {junk[15:8], s};
    @(negedge clk_i);
    cfg_idx   <= sefr_pkg::CFG_END;
    cfg_wdata <= {junk[7:0], e};
    @(negedge clk_i);
    cfg_idx   <= sefr_pkg::CFG_SIZE;
    cfg_wdata <= {junk[15:7], z};
    @(negedge clk_i);
    cfg_idx   <= sefr_pkg::CFG_TIMEOUT;
    cfg_wdata <= t;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    sof_val  = s;
    eof_val  = e;
    size_val = z;
    tmo_val  = t;
    settings_used++;
  endtask

  // Mostly well-formed frames, with overflows, timeouts and noise mixed in.
  task automatic run_phase(int unsigned target);
    int unsigned first;
    int unsigned pick;
    int unsigned cap;
    int unsigned body;
    first = items_planned;
    cap = 32'(size_val);
    if (cap < 2) begin
      cap = 2;
    end else if (cap > FRAME_DEPTH) begin
      cap = FRAME_DEPTH;
    end
    while (items_planned - first < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if ($urandom_range(0, 9) == 0) begin
          body = cap - 2;
        end else begin
          body = $urandom_range(0, (cap - 2 > 8) ? 8 : cap - 2);
        end
        push_frame(body);
        if ($urandom_range(0, 3) == 0) begin
          push_item(sefr_pkg::MODE_BYTE, byte_t'($urandom));
        end
        push_item(sefr_pkg::MODE_EVAL, byte_t'($urandom));
      end else if (pick < 72) begin
        push_item(sefr_pkg::MODE_BYTE, sof_val);
        repeat (cap - 1) push_item(sefr_pkg::MODE_BYTE, body_byte());
        push_item(sefr_pkg::MODE_EVAL, byte_t'($urandom));
      end else if (pick < 84 && tmo_val <= 40) begin
        push_item(sefr_pkg::MODE_BYTE, sof_val);
        repeat ($urandom_range(0, (cap - 2 > 3) ? 3 : cap - 2)) begin
          push_item(sefr_pkg::MODE_BYTE, body_byte());
        end
        repeat (tmo_val + 2) push_item(sefr_pkg::MODE_TICK, byte_t'($urandom));
        push_item(sefr_pkg::MODE_BYTE, eof_val);
        push_item(sefr_pkg::MODE_EVAL, byte_t'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          push_item(mode_t'($urandom_range(0, 3)), byte_t'($urandom));
        end
      end
    end
  endtask

  // Stimulus: directed cases, then random phases under several register settings.
  initial begin
    in_ch.valid     = 1'b0;
    in_ch.mode      = sefr_pkg::MODE_BYTE;
    in_ch.data_byte = '0;
    out_ch.ready    = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Idle behavior: evaluate with no frame, unused mode, tick and stray bytes.
    push_item(sefr_pkg::MODE_EVAL, 8'h00);
    push_item(MODE_UNUSED, 8'hFF);
    push_item(sefr_pkg::MODE_TICK, 8'hA5);
    push_item(sefr_pkg::MODE_BYTE, 8'h00);
    push_item(sefr_pkg::MODE_BYTE, 8'hFF);
    // Frame holding only the start byte.
    push_item(sefr_pkg::MODE_BYTE, sefr_pkg::START_RST);
    push_item(sefr_pkg::MODE_BYTE, sefr_pkg::END_RST);
    push_item(sefr_pkg::MODE_EVAL, 8'h00);
    // Start byte inside a frame is data; bytes and ticks are ignored once ready.
    push_item(sefr_pkg::MODE_BYTE, sefr_pkg::START_RST);
    push_item(sefr_pkg::MODE_BYTE, 8'h00);
    push_item(sefr_pkg::MODE_BYTE, 8'hFF);
    push_item(sefr_pkg::MODE_BYTE, sefr_pkg::START_RST);
    push_item(sefr_pkg::MODE_TICK, 8'h00);
    push_item(sefr_pkg::MODE_BYTE, sefr_pkg::END_RST);
    push_item(sefr_pkg::MODE_BYTE, 8'h55);
    push_item(sefr_pkg::MODE_TICK, 8'h00);
    push_item(sefr_pkg::MODE_BYTE, sefr_pkg::START_RST);
    push_item(MODE_UNUSED, 8'h00);
    push_item(sefr_pkg::MODE_EVAL, 8'hFF);
    push_item(sefr_pkg::MODE_EVAL, 8'h00);
    drain();

    // Receiver holds off for a long stretch while back-to-back frames pile up.
    tx_idle_on = 1'b0;
    hold_gen++;
    repeat (3) begin
      push_frame($urandom_range(10, 20));
      push_item(sefr_pkg::MODE_EVAL, byte_t'($urandom));
    end
    drain();

    tx_idle_on = 1'b1;
    run_phase(PHASE_ITEMS);
    // Sender waits here for every outstanding byte.
    drain();
    run_phase(PHASE_ITEMS);

    drain();
    load_settings(8'h00, 8'hFF, 7'd2, 16'd0);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_phase(PHASE_ITEMS);

    drain();
    load_settings(8'hFF, 8'h00, 7'd127, 16'hFFFF);
    tx_idle_on = 1'b1;
    run_phase(PHASE_ITEMS);

    // Same value opens and closes a frame.
    drain();
    load_settings(8'h7E, 8'h7E, 7'd16, 16'd5);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    run_phase(PHASE_ITEMS);

    // Sizes below two behave as two.
    drain();
    load_settings(byte_t'($urandom), byte_t'($urandom), 7'd1, 16'd3);
    tx_idle_on = 1'b1;
    run_phase(PHASE_ITEMS);

    drain();
    load_settings(byte_t'($urandom), byte_t'($urandom), 7'd0,
                  tmo_t'($urandom_range(0, 30)));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_phase(PHASE_ITEMS);

    drain();
    load_settings(byte_t'($urandom), byte_t'($urandom), len_t'($urandom_range(2, 64)),
                  tmo_t'($urandom_range(0, 40)));
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_phase(PHASE_ITEMS);
    drain();

    mismatches += frame_expect.size();
    $display("Accepted %0d input items and checked %0d frame bytes in %0d frames.",
             items_taken, results_checked, frames_seen);
    $display("Register settings applied: %0d; mismatches: %0d.", settings_used + 1, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
